[design/obd_rpm_response_parser_defines.svh]
// Assertion macros used by the port-level checker of the engine speed reply parser.
// No dependencies; include by bare file name.
`ifndef OBD_RPM_RESPONSE_PARSER_DEFINES_SVH
`define OBD_RPM_RESPONSE_PARSER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ORPM_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define ORPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/orpm_pkg.sv]
// Types, character codes and helper functions for the engine speed reply parser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package orpm_pkg;

	localparam int RpmW    = 14;
	localparam int CoolW   = 24;
	localparam int TimeW   = 32;
	localparam int CfgIdxW = 3;
	localparam int CfgDatW = 24;

	localparam logic [7:0] ChGt    = 8'h3E;
	localparam logic [7:0] ChCr    = 8'h0D;
	localparam logic [7:0] ChLf    = 8'h0A;
	localparam logic [7:0] ChSpace = 8'h20;
	localparam logic [7:0] ChFour  = 8'h34;
	localparam logic [7:0] ChOne   = 8'h31;
	localparam logic [7:0] ChZero  = 8'h30;
	localparam logic [7:0] ChNine  = 8'h39;
	localparam logic [7:0] ChUpA   = 8'h41;
	localparam logic [7:0] ChUpC   = 8'h43;
	localparam logic [7:0] ChUpF   = 8'h46;
	localparam logic [7:0] ChLoA   = 8'h61;
	localparam logic [7:0] ChLoZ   = 8'h7A;
	localparam logic [7:0] CaseOfs = 8'h20;

	localparam logic [2:0] MatchFull = 3'd4;
	localparam logic [2:0] CapFull   = 3'd4;

	typedef enum logic {
		KIND_RPM  = 1'b0,
		KIND_DISC = 1'b1
	} kind_e;

	typedef enum logic [CfgIdxW-1:0] {
		REG_THRESHOLD  = 3'd0,
		REG_COOLDOWN   = 3'd1,
		REG_LOGO_IGN   = 3'd2,
		REG_LOGO_ENG   = 3'd3,
		REG_LOGO_OFF   = 3'd4
	} cfg_reg_e;

	typedef struct packed {
		kind_e             kind;
		logic [RpmW-1:0]   rpm;
		logic [TimeW-1:0]  now;
	} op_t;

	typedef struct packed {
		logic [RpmW-1:0]   threshold;
		logic [CoolW-1:0]  cooldown;
		logic              logo_ign;
		logic              logo_eng;
		logic              logo_off;
	} cfg_t;

	typedef struct packed {
		logic push;
		logic full;
	} q_in_t;

	typedef struct packed {
		logic pop;
		logic empty;
	} q_out_t;

	function automatic logic [7:0] pattern_char(input logic [1:0] idx);
		logic [7:0] ch;
		unique case (idx)
			2'd0: ch = ChFour;
			2'd1: ch = ChOne;
			2'd2: ch = ChZero;
			2'd3: ch = ChUpC;
			default: ch = ChFour;
		endcase
		return ch;
	endfunction

	// {bad, digit}
	function automatic logic [4:0] hex_value(input logic [7:0] ch);
		logic [7:0] t;
		t = 8'd0;
		if (ch >= ChZero && ch <= ChNine) begin
			t = ch - ChZero;
			return {1'b0, t[3:0]};
		end
		if (ch >= ChUpA && ch <= ChUpF) begin
			t = ch - ChUpA + 8'd10;
			return {1'b0, t[3:0]};
		end
		return 5'b10000;
	endfunction

endpackage

[design/obd_rpm_response_parser.sv]
// Engine speed reply parser: an input beat goes through front classify, the queue
// and the back update into the output register.
// Throughput one input beat per cycle while the two-entry queue is not full; output stalls back up into it.
// Reset clears line state, flags, peak, logo state and the queue; configuration
// registers return to their defaults. No clearing pass.
`timescale 1ns / 1ps

module obd_rpm_response_parser import orpm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [7:0]  byte_value,
	input  logic [31:0] now_ms,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        result_kind,
	output logic [13:0] rpm,
	output logic [13:0] max_rpm,
	output logic        ignition_on,
	output logic        engine_running,
	output logic        start_logo,
	output logic        leaving_logo,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	cfg_t   cfg_q;
	q_in_t  wr_ctl;
	op_t    wr_op;
	q_out_t rd_ctl;
	op_t    rd_op;
	logic   q_full;
	logic   q_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold <= 14'd300;
			cfg_q.cooldown  <= 24'd10000;
			cfg_q.logo_ign  <= 1'b1;
			cfg_q.logo_eng  <= 1'b1;
			cfg_q.logo_off  <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_THRESHOLD: cfg_q.threshold <= cfg_data[RpmW-1:0];
				REG_COOLDOWN:  cfg_q.cooldown  <= cfg_data;
				REG_LOGO_IGN:  cfg_q.logo_ign  <= cfg_data[0];
				REG_LOGO_ENG:  cfg_q.logo_eng  <= cfg_data[0];
				REG_LOGO_OFF:  cfg_q.logo_off  <= cfg_data[0];
				default:       cfg_q           <= cfg_q;
			endcase
		end
	end

	orpm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.byte_value (byte_value),
		.now_ms     (now_ms),
		.q_full     (q_full),
		.q_ctl      (wr_ctl),
		.q_op       (wr_op)
	);

	orpm_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_ctl (wr_ctl),
		.wr_op  (wr_op),
		.rd_pop (q_pop),
		.rd_ctl (rd_ctl),
		.rd_op  (rd_op),
		.full   (q_full)
	);

	orpm_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.q_ctl          (rd_ctl),
		.q_op           (rd_op),
		.q_pop          (q_pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.result_kind    (result_kind),
		.rpm            (rpm),
		.max_rpm        (max_rpm),
		.ignition_on    (ignition_on),
		.engine_running (engine_running),
		.start_logo     (start_logo),
		.leaving_logo   (leaving_logo)
	);

endmodule

[design/orpm_front.sv]
// Front part: line assembly, "410C" match and four-digit capture.
// Depends on orpm_pkg; emits one op per finished reading or disconnect.
`timescale 1ns / 1ps

module orpm_front import orpm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [7:0]  byte_value,
	input  logic [31:0] now_ms,
	input  logic        q_full,
	output q_in_t       q_ctl,
	output op_t         q_op
);

	logic [2:0]  match_q;
	logic [2:0]  count_q;
	logic [15:0] value_q;
	logic        bad_q;
	logic        text_q;

	logic        accept;
	logic        term;
	logic [7:0]  cu;
	logic [4:0]  hx;
	logic        line_ok;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign term     = (byte_value == ChGt) || (byte_value == ChCr) || (byte_value == ChLf);
	assign cu       = (byte_value >= ChLoA && byte_value <= ChLoZ) ?
		byte_value - CaseOfs : byte_value;
	assign hx       = hex_value(cu);
	assign line_ok  = text_q && (match_q == MatchFull) && (count_q == CapFull) && !bad_q;

	always_comb begin
		q_ctl.full = q_full;
		q_ctl.push = accept && (command || (term && line_ok));
		q_op.kind  = command ? KIND_DISC : KIND_RPM;
		q_op.rpm   = command ? '0 : value_q[15:2];
		q_op.now   = now_ms;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= '0;
			count_q <= '0;
			value_q <= '0;
			bad_q   <= 1'b0;
			text_q  <= 1'b0;
		end else if (accept && !command) begin
			if (term) begin
				match_q <= '0;
				count_q <= '0;
				value_q <= '0;
				bad_q   <= 1'b0;
				text_q  <= 1'b0;
			end else begin
				text_q <= 1'b1;
				if (byte_value != ChSpace) begin
					if (match_q < MatchFull) begin
						if (cu == pattern_char(match_q[1:0]))
							match_q <= match_q + 3'd1;
						else
							match_q <= (cu == ChFour) ? 3'd1 : 3'd0;
					end else if (count_q < CapFull) begin
						if (hx[4])
							bad_q <= 1'b1;
						else
							value_q <= {value_q[11:0], hx[3:0]};
						count_q <= count_q + 3'd1;
					end
				end
			end
		end
	end

endmodule

[design/orpm_queue.sv]
// Two-entry op queue between the front and back parts.
// Depends on orpm_pkg for the op type and queue control structs.
`timescale 1ns / 1ps

module orpm_queue import orpm_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  q_in_t  wr_ctl,
	input  op_t    wr_op,
	input  logic   rd_pop,
	output q_out_t rd_ctl,
	output op_t    rd_op,
	output logic   full
);

	op_t        slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;

	assign full         = (fill_q == 2'd2);
	assign rd_ctl.empty = (fill_q == 2'd0);
	assign rd_ctl.pop   = rd_pop && !rd_ctl.empty;
	assign rd_op        = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_ctl.push)
			slot_q[wr_ptr_q] <= wr_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (wr_ctl.push)
				wr_ptr_q <= !wr_ptr_q;
			if (rd_ctl.pop)
				rd_ptr_q <= !rd_ptr_q;
			case ({wr_ctl.push, rd_ctl.pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

[design/orpm_back.sv]
// Back part: peak, ignition and engine flags, logo triggers, output register.
// Depends on orpm_pkg; pops one op per cycle while the output can advance.
`timescale 1ns / 1ps

module orpm_back import orpm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  q_out_t      q_ctl,
	input  op_t         q_op,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        result_kind,
	output logic [13:0] rpm,
	output logic [13:0] max_rpm,
	output logic        ignition_on,
	output logic        engine_running,
	output logic        start_logo,
	output logic        leaving_logo
);

	logic [RpmW-1:0]  peak_q;
	logic             ign_q;
	logic             eng_q;
	logic             start_done_q;
	logic             leave_done_q;
	logic [TimeW-1:0] last_q;

	logic             valid_q;
	kind_e            kind_q;
	logic [RpmW-1:0]  rpm_q;
	logic [RpmW-1:0]  max_q;
	logic             ign_out_q;
	logic             eng_out_q;
	logic             start_out_q;
	logic             leave_out_q;

	logic             take;
	logic [RpmW-1:0]  peak_nx;
	logic             eng_nx;
	logic             edge_hit;
	logic [TimeW-1:0] elapsed;
	logic             fire;
	logic             leave;

	assign q_pop   = !valid_q || out_ready;
	assign take    = q_ctl.pop;
	assign peak_nx = (q_op.rpm > peak_q) ? q_op.rpm : peak_q;
	assign eng_nx  = (q_op.rpm > cfg.threshold);
	assign edge_hit = (!ign_q && cfg.logo_ign) || (!eng_q && eng_nx && cfg.logo_eng);
	assign elapsed = q_op.now - last_q;
	assign fire    = !start_done_q && edge_hit && (elapsed > {8'd0, cfg.cooldown});
	assign leave   = ign_q && cfg.logo_off && !leave_done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q       <= '0;
			ign_q        <= 1'b0;
			eng_q        <= 1'b0;
			start_done_q <= 1'b0;
			leave_done_q <= 1'b0;
			last_q       <= '0;
			valid_q      <= 1'b0;
		end else begin
			if (take) begin
				valid_q <= 1'b1;
				if (q_op.kind == KIND_DISC) begin
					ign_q        <= 1'b0;
					eng_q        <= 1'b0;
					start_done_q <= 1'b0;
					if (leave)
						leave_done_q <= 1'b1;
				end else begin
					peak_q <= peak_nx;
					ign_q  <= 1'b1;
					eng_q  <= eng_nx;
					if (fire) begin
						start_done_q <= 1'b1;
						leave_done_q <= 1'b0;
						last_q       <= q_op.now;
					end
				end
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			kind_q <= q_op.kind;
			if (q_op.kind == KIND_DISC) begin
				rpm_q       <= '0;
				max_q       <= peak_q;
				ign_out_q   <= 1'b0;
				eng_out_q   <= 1'b0;
				start_out_q <= 1'b0;
				leave_out_q <= leave;
			end else begin
				rpm_q       <= q_op.rpm;
				max_q       <= peak_nx;
				ign_out_q   <= 1'b1;
				eng_out_q   <= eng_nx;
				start_out_q <= fire;
				leave_out_q <= 1'b0;
			end
		end
	end

	assign out_valid      = valid_q;
	assign result_kind    = kind_q;
	assign rpm            = rpm_q;
	assign max_rpm        = max_q;
	assign ignition_on    = ign_out_q;
	assign engine_running = eng_out_q;
	assign start_logo     = start_out_q;
	assign leaving_logo   = leave_out_q;

endmodule

[design/orpm_checker.sv]
// Port-level checker for the engine speed reply parser, bound to the top level.
// Depends on orpm_pkg and obd_rpm_response_parser_defines.svh.
`timescale 1ns / 1ps
`include "obd_rpm_response_parser_defines.svh"

module orpm_checker import orpm_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        result_kind,
	input logic [13:0] rpm,
	input logic [13:0] max_rpm,
	input logic        ignition_on,
	input logic        engine_running,
	input logic        start_logo,
	input logic        leaving_logo
);

	`ORPM_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(rpm) && $stable(max_rpm) && $stable(result_kind), "result beat changed while stalled")
	`ORPM_ASSERT_IMPLY(a_disc_fields, clk, arst_n, out_valid && result_kind == KIND_DISC, rpm == 14'd0 && !start_logo && !ignition_on && !engine_running, "disconnect report carries reading fields")
	`ORPM_ASSERT_IMPLY(a_rpm_peak, clk, arst_n, out_valid && result_kind == KIND_RPM, ignition_on && !leaving_logo && max_rpm >= rpm, "reading without ignition or below peak")
	`ORPM_ASSERT_IMPLY(a_logo_excl, clk, arst_n, out_valid, !(start_logo && leaving_logo), "start and leaving logo in one beat")

endmodule

bind obd_rpm_response_parser orpm_checker u_orpm_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.result_kind    (result_kind),
	.rpm            (rpm),
	.max_rpm        (max_rpm),
	.ignition_on    (ignition_on),
	.engine_running (engine_running),
	.start_logo     (start_logo),
	.leaving_logo   (leaving_logo)
);
